@@ rtl/core/fmprc_pkg.sv @@
// shared constants, types and match function for the first-match rule classifier
package fmprc_pkg;

	localparam int MAX_RULES = 64;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 7;
	localparam int PROTO_W   = 9;
	localparam int ADDR_W    = 32;
	localparam int PORT_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	localparam logic [PROTO_W-1:0] PROTO_WILD = 9'd256;
	localparam logic [PORT_W-1:0]  PORT_ANY   = 17'h1FFFF;

	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_LOAD     = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RULES_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ACCEPT = 2'd1;

	localparam int WILD_SRC     = 0;
	localparam int WILD_DST     = 1;
	localparam int FLAG_ACCEPT  = 0;
	localparam int FLAG_ENABLED = 1;

	typedef struct packed {
		logic [PROTO_W-1:0] proto;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [1:0]         wild;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic [1:0]         flags;
	} rule_t;

	function automatic logic rule_hit(
		input rule_t              r,
		input logic [PROTO_W-1:0] proto,
		input logic [ADDR_W-1:0]  src,
		input logic [ADDR_W-1:0]  dst,
		input logic [PORT_W-1:0]  sport,
		input logic [PORT_W-1:0]  dport
	);
		logic p_ok, s_ok, d_ok, sp_ok, dp_ok;
		p_ok  = (r.proto == proto) || (r.proto == PROTO_WILD);
		s_ok  = (r.src == src) || r.wild[WILD_SRC];
		d_ok  = (r.dst == dst) || r.wild[WILD_DST];
		sp_ok = (r.sport == sport) || (r.sport == PORT_ANY);
		dp_ok = (r.dport == dport) || (r.dport == PORT_ANY);
		return p_ok && s_ok && d_ok && sp_ok && dp_ok;
	endfunction

endpackage

@@ rtl/core/fmprc_if.sv @@
// valid/ready channel interfaces for packet items, verdicts and register writes
interface fmprc_in_if import fmprc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [SLOT_W-1:0]        rule_slot;
	logic [PROTO_W-1:0]       proto_code;
	logic [ADDR_W-1:0]        source_addr;
	logic [ADDR_W-1:0]        dest_addr;
	logic [1:0]               addr_wild;
	logic signed [PORT_W-1:0] source_port;
	logic signed [PORT_W-1:0] dest_port;
	logic [1:0]               rule_flags;
	logic                     conn_state_hit;
	logic                     ports_valid;

	modport source (
		output valid, cmd, rule_slot, proto_code, source_addr, dest_addr, addr_wild,
			source_port, dest_port, rule_flags, conn_state_hit, ports_valid,
		input ready
	);
	modport sink (
		input valid, cmd, rule_slot, proto_code, source_addr, dest_addr, addr_wild,
			source_port, dest_port, rule_flags, conn_state_hit, ports_valid,
		output ready
	);
endinterface

interface fmprc_out_if import fmprc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accept;
	logic              rule_matched;
	logic [SLOT_W-1:0] matched_slot;

	modport source (output valid, accept, rule_matched, matched_slot, input ready);
	modport sink (input valid, accept, rule_matched, matched_slot, output ready);
endinterface

interface fmprc_cfg_if import fmprc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/first_match_packet_rule_classifier.sv @@
// first-match packet rule classifier: rule table, sequential scan and verdict register
// load item: writes the table, no verdict
// connection hit or bad ports: verdict registered straight from the transaction
// scan: one rule compared per cycle from the table read port; the verdict is registered
// when a rule matches or after the last rule in use, once the output side is free
// reset clears control, registers and verdict; table contents stay undefined until loaded
module first_match_packet_rule_classifier import fmprc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fmprc_in_if.sink      in_ch,
	fmprc_out_if.source   out_ch,
	fmprc_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   rules_in_use_q;
	logic               default_accept_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   issue_idx_q;
	logic               chk_vld_q;
	logic [SLOT_W-1:0]  chk_idx_q;
	rule_t              rd_q;

	logic [PROTO_W-1:0] pkt_proto_q;
	logic [ADDR_W-1:0]  pkt_src_q;
	logic [ADDR_W-1:0]  pkt_dst_q;
	logic [PORT_W-1:0]  pkt_sport_q;
	logic [PORT_W-1:0]  pkt_dport_q;

	logic               out_valid_q;
	logic               out_accept_q;
	logic               out_matched_q;
	logic [SLOT_W-1:0]  out_slot_q;

	rule_t              rule_mem [MAX_RULES];

	logic out_free, in_fire, load_fire, hit, scan_end, finish, issue;
	rule_t wr_rule;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign load_fire = in_fire && (in_ch.cmd == CMD_LOAD);
	assign cfg.ready = 1'b1;

	assign hit      = chk_vld_q && rule_hit(rd_q, pkt_proto_q, pkt_src_q, pkt_dst_q,
		pkt_sport_q, pkt_dport_q);
	assign scan_end = !hit && (issue_idx_q == count_q);
	assign finish   = (state_q == S_SCAN) && (hit || scan_end) && out_free;
	assign issue    = (state_q == S_SCAN) && !hit && !scan_end;

	always_comb begin
		wr_rule.proto = in_ch.proto_code;
		wr_rule.src   = in_ch.source_addr;
		wr_rule.dst   = in_ch.dest_addr;
		wr_rule.wild  = in_ch.addr_wild;
		wr_rule.sport = in_ch.source_port;
		wr_rule.dport = in_ch.dest_port;
		wr_rule.flags = in_ch.rule_flags;
	end

	// rule table
	always_ff @(posedge clk) begin
		if (load_fire && (int'(in_ch.rule_slot) < MAX_RULES)) begin
			rule_mem[in_ch.rule_slot] <= wr_rule;
		end
		if (issue) begin
			rd_q <= rule_mem[issue_idx_q[SLOT_W-1:0]];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_in_use_q   <= '0;
			default_accept_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_RULES_IN_USE:   rules_in_use_q <= cfg.data;
				CFG_DEFAULT_ACCEPT: default_accept_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// packet header held for the scan
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pkt_proto_q <= in_ch.proto_code;
			pkt_src_q   <= in_ch.source_addr;
			pkt_dst_q   <= in_ch.dest_addr;
			pkt_sport_q <= in_ch.source_port;
			pkt_dport_q <= in_ch.dest_port;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			chk_vld_q   <= 1'b0;
			chk_idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_ch.cmd == CMD_CLASSIFY) && !in_ch.conn_state_hit
						&& in_ch.ports_valid) begin
						state_q     <= S_SCAN;
						count_q     <= (int'(rules_in_use_q) > MAX_RULES) ?
							CNT_W'(MAX_RULES) : rules_in_use_q;
						issue_idx_q <= '0;
						chk_vld_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (finish) begin
						state_q   <= S_IDLE;
						chk_vld_q <= 1'b0;
					end else if (issue) begin
						chk_vld_q   <= 1'b1;
						chk_idx_q   <= issue_idx_q[SLOT_W-1:0];
						issue_idx_q <= issue_idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			out_accept_q  <= 1'b0;
			out_matched_q <= 1'b0;
			out_slot_q    <= '0;
		end else begin
			if (in_fire && (in_ch.cmd == CMD_CLASSIFY)
				&& (in_ch.conn_state_hit || !in_ch.ports_valid)) begin
				out_valid_q   <= 1'b1;
				out_accept_q  <= in_ch.conn_state_hit;
				out_matched_q <= 1'b0;
				out_slot_q    <= '0;
			end else if (finish) begin
				out_valid_q <= 1'b1;
				if (hit && rd_q.flags[FLAG_ENABLED]) begin
					out_accept_q  <= rd_q.flags[FLAG_ACCEPT];
					out_matched_q <= 1'b1;
					out_slot_q    <= chk_idx_q;
				end else begin
					out_accept_q  <= default_accept_q;
					out_matched_q <= 1'b0;
					out_slot_q    <= '0;
				end
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.accept       = out_accept_q;
	assign out_ch.rule_matched = out_matched_q;
	assign out_ch.matched_slot = out_slot_q;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the first-match packet rule classifier
module testbench;
	import fmprc_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam int MAX_REPORTS    = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	localparam logic [1:0] ADDR_EXACT = 2'b00;
	localparam logic [1:0] DST_ANY    = 2'b10;
	localparam logic [1:0] ADDRS_ANY  = 2'b11;

	localparam logic [1:0] RULE_ACCEPT     = 2'b11;
	localparam logic [1:0] RULE_DROP       = 2'b10;
	localparam logic [1:0] RULE_OFF_ACCEPT = 2'b01;
	localparam logic [1:0] RULE_OFF_DROP   = 2'b00;

	localparam logic [PROTO_W-1:0] PROTO_ICMP = 9'd1;
	localparam logic [PROTO_W-1:0] PROTO_TCP  = 9'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP  = 9'd17;
	localparam logic [PROTO_W-1:0] PROTO_RSVD = 9'd257;

	localparam logic [ADDR_W-1:0] HOST_A = 32'h0A00_0001;
	localparam logic [ADDR_W-1:0] HOST_B = 32'hC0A8_0101;
	localparam logic [ADDR_W-1:0] ADDR_ZERO = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] ADDR_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               cmd;
		logic [SLOT_W-1:0]  slot;
		logic [PROTO_W-1:0] proto;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [1:0]         wild;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic [1:0]         flags;
		logic               hit;
		logic               pvalid;
	} pkt_item_t;

	typedef struct packed {
		logic              accept;
		logic              rule_matched;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	fmprc_in_if  in_ch ();
	fmprc_out_if out_ch ();
	fmprc_cfg_if cfg ();

	first_match_packet_rule_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	pkt_item_t         pending_items[$];
	verdict_t          verdicts_due[$];
	rule_t             rule_shadow[MAX_RULES];
	logic [CNT_W-1:0]  scan_count = '0;
	logic              policy_accept = 1'b0;
	pkt_item_t         item_on_bus;
	verdict_t          want;
	int                pushed_count = 0;
	int                taken_count = 0;
	int                errors = 0;
	int                src_gap = 0;
	int                sink_gap = 0;
	int                hold_requests = 0;
	int                holds_done = 0;
	int                hold_len = 0;
	int                quiet_cycles = 0;
	bit                idle_on = 1'b0;

	function automatic void predict_item(input pkt_item_t it);
		verdict_t v;
		rule_t    r;
		int       n;
		if (it.cmd == CMD_LOAD) begin
			rule_shadow[it.slot] = '{it.proto, it.src, it.dst, it.wild, it.sport, it.dport,
				it.flags};
			return;
		end
		v = '0;
		if (it.hit) begin
			v.accept = 1'b1;
		end else if (it.pvalid) begin
			v.accept = policy_accept;
			n = (scan_count > MAX_RULES) ? MAX_RULES : scan_count;
			for (int i = 0; i < n; i++) begin
				r = rule_shadow[i];
				if ((r.proto == it.proto || r.proto == PROTO_WILD) &&
						(r.src == it.src || r.wild[WILD_SRC]) &&
						(r.dst == it.dst || r.wild[WILD_DST]) &&
						(r.sport == it.sport || r.sport == PORT_ANY) &&
						(r.dport == it.dport || r.dport == PORT_ANY)) begin
					if (r.flags[FLAG_ENABLED]) begin
						v.accept = r.flags[FLAG_ACCEPT];
						v.rule_matched = 1'b1;
						v.slot = SLOT_W'(i);
					end
					break;
				end
			end
		end
		verdicts_due.push_back(v);
	endfunction

	function automatic logic [PROTO_W-1:0] pick_proto(input bit allow_any);
		case ($urandom_range(0, 9))
			0: return PROTO_TCP;
			1: return PROTO_UDP;
			2: return PROTO_ICMP;
			3: return 9'd0;
			4: return 9'd255;
			5: return PROTO_W'(PROTO_RSVD + $urandom_range(0, 254));
			6: return PROTO_W'($urandom_range(0, 255));
			default: return allow_any ? PROTO_WILD : PROTO_TCP;
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return ADDR_ZERO;
			1: return ADDR_ONES;
			2: return HOST_A;
			3: return HOST_B;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PORT_W-1:0] pick_port(input bit allow_any);
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd80;
			2: return 17'd443;
			3: return 17'd65535;
			4, 5: return PORT_W'($urandom_range(0, 65535));
			default: return allow_any ? PORT_ANY : 17'd80;
		endcase
	endfunction

	function automatic pkt_item_t rule_item(input logic [SLOT_W-1:0] slot,
			input logic [PROTO_W-1:0] proto, input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst, input logic [1:0] wild,
			input logic [PORT_W-1:0] sport, input logic [PORT_W-1:0] dport,
			input logic [1:0] flags);
		pkt_item_t it;
		it = '{CMD_LOAD, slot, proto, src, dst, wild, sport, dport, flags, 1'b0, 1'b0};
		it.hit = 1'($urandom_range(0, 1));
		it.pvalid = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic pkt_item_t packet_item(input logic [PROTO_W-1:0] proto,
			input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
			input logic [PORT_W-1:0] sport, input logic [PORT_W-1:0] dport,
			input logic hit, input logic pvalid);
		pkt_item_t it;
		it = '{CMD_CLASSIFY, 6'd0, proto, src, dst, 2'd0, sport, dport, 2'd0, hit, pvalid};
		it.slot = SLOT_W'($urandom);
		it.wild = 2'($urandom);
		it.flags = 2'($urandom);
		return it;
	endfunction

	function automatic pkt_item_t make_rule(input logic [SLOT_W-1:0] slot);
		logic [1:0] flags;
		flags[FLAG_ENABLED] = ($urandom_range(0, 4) != 0);
		flags[FLAG_ACCEPT] = 1'($urandom_range(0, 1));
		return rule_item(slot, pick_proto(1'b1), pick_addr(), pick_addr(),
			2'($urandom_range(0, 3)), pick_port(1'b1), pick_port(1'b1), flags);
	endfunction

	task automatic queue_item(input pkt_item_t it);
		pending_items.push_back(it);
		pushed_count++;
	endtask

	task automatic settle();
		while (!(taken_count == pushed_count && verdicts_due.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_RULES_IN_USE)
			scan_count = val;
		else if (idx == CFG_DEFAULT_ACCEPT)
			policy_accept = val[0];
	endtask

	task automatic report(input string what, input int expected, input int actual);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, expected, actual);
	endtask

	// driver: one packet transaction per handshake, random gaps between items while idle_on is set
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_item(item_on_bus);
				taken_count++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_on_bus = pending_items.pop_front();
					in_ch.cmd <= item_on_bus.cmd;
					in_ch.rule_slot <= item_on_bus.slot;
					in_ch.proto_code <= item_on_bus.proto;
					in_ch.source_addr <= item_on_bus.src;
					in_ch.dest_addr <= item_on_bus.dst;
					in_ch.addr_wild <= item_on_bus.wild;
					in_ch.source_port <= item_on_bus.sport;
					in_ch.dest_port <= item_on_bus.dport;
					in_ch.rule_flags <= item_on_bus.flags;
					in_ch.conn_state_hit <= item_on_bus.hit;
					in_ch.ports_valid <= item_on_bus.pvalid;
					in_ch.valid <= 1'b1;
					if (idle_on && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 16);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: verdict check and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: verdict transaction, expected none, actual %0b/%0b/%0d",
							$time, out_ch.accept, out_ch.rule_matched, out_ch.matched_slot);
				end else begin
					want = verdicts_due.pop_front();
					if (out_ch.accept !== want.accept)
						report("accept", want.accept, out_ch.accept);
					if (out_ch.rule_matched !== want.rule_matched)
						report("rule_matched", want.rule_matched, out_ch.rule_matched);
					if (out_ch.matched_slot !== want.slot)
						report("matched_slot", want.slot, out_ch.matched_slot);
				end
			end
			if (holds_done != hold_requests) begin
				out_ch.ready <= 1'b0;
				hold_len++;
				if (hold_len == HOLD_CYCLES) begin
					holds_done++;
					hold_len = 0;
				end
			end else if (sink_gap != 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("first_match_packet_rule_classifier test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pkt_item_t        it;
		rule_t            r;
		int               eff;
		logic [CFG_DAT_W-1:0] cnt;
		logic [CFG_DAT_W-1:0] wdat;
		logic             dacc;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_CLASSIFY;
		in_ch.rule_slot = '0;
		in_ch.proto_code = '0;
		in_ch.source_addr = '0;
		in_ch.dest_addr = '0;
		in_ch.addr_wild = '0;
		in_ch.source_port = '0;
		in_ch.dest_port = '0;
		in_ch.rule_flags = '0;
		in_ch.conn_state_hit = 1'b0;
		in_ch.ports_valid = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_RULES_IN_USE;
		cfg.data = '0;
		for (int i = 0; i < MAX_RULES; i++)
			rule_shadow[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty scan: connection hit, bad ports, default drop
		write_reg(CFG_RULES_IN_USE, 7'd0);
		write_reg(CFG_DEFAULT_ACCEPT, 7'd0);
		idle_on = 1'b1;
		@(negedge clk);
		queue_item(packet_item(PROTO_TCP, HOST_A, HOST_B, 17'd1234, 17'd80, 1'b1, 1'b0));
		queue_item(packet_item(PROTO_UDP, HOST_A, HOST_B, 17'd53, 17'd53, 1'b0, 1'b0));
		queue_item(packet_item(PROTO_TCP, HOST_B, HOST_A, 17'd80, 17'd1234, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_WILD, ADDR_ONES, ADDR_ZERO, PORT_ANY, PORT_ANY, 1'b0,
			1'b1));
		queue_item(rule_item(6'd0, PROTO_RSVD, HOST_A, HOST_B, ADDR_EXACT, 17'd1234, 17'd80,
			RULE_ACCEPT));
		queue_item(rule_item(6'd1, PROTO_TCP, ADDR_ZERO, ADDR_ONES, ADDR_EXACT, 17'd0,
			17'd65535, RULE_DROP));
		queue_item(rule_item(6'd2, PROTO_UDP, ADDR_ZERO, ADDR_ZERO, ADDRS_ANY, PORT_ANY,
			PORT_ANY, RULE_OFF_ACCEPT));
		queue_item(rule_item(6'd3, PROTO_WILD, ADDR_ONES, ADDR_ZERO, DST_ANY, PORT_ANY,
			17'd443, RULE_ACCEPT));
		queue_item(rule_item(6'd4, PROTO_TCP, ADDR_ZERO, ADDR_ZERO, ADDRS_ANY, PORT_ANY,
			PORT_ANY, RULE_OFF_DROP));
		queue_item(rule_item(6'd5, PROTO_WILD, ADDR_ZERO, ADDR_ZERO, ADDRS_ANY, PORT_ANY,
			PORT_ANY, RULE_DROP));
		settle();

		// six directed rules, default accept
		write_reg(CFG_RULES_IN_USE, 7'd6);
		write_reg(CFG_DEFAULT_ACCEPT, 7'd1);
		write_reg(CFG_NO_REG, 7'h7F);
		@(negedge clk);
		queue_item(packet_item(PROTO_RSVD, HOST_A, HOST_B, 17'd1234, 17'd80, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_WILD, HOST_A, HOST_B, 17'd1234, 17'd80, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_TCP, ADDR_ZERO, ADDR_ONES, 17'd0, 17'd65535, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_UDP, $urandom, $urandom, PORT_ANY, PORT_ANY, 1'b0, 1'b1));
		queue_item(packet_item(9'd255, ADDR_ONES, ADDR_ZERO, 17'd65535, 17'd443, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_TCP, 32'd1, ADDR_ONES, 17'd0, 17'd65535, 1'b0, 1'b1));
		queue_item(packet_item(PROTO_UDP, HOST_B, HOST_A, 17'd7, 17'd9, 1'b1, 1'b0));
		queue_item(packet_item(PROTO_TCP, HOST_A, HOST_B, 17'd1234, 17'd80, 1'b0, 1'b0));
		queue_item(packet_item(9'd0, ADDR_ZERO, HOST_B, PORT_ANY, PORT_ANY, 1'b0, 1'b1));
		for (int s = 0; s < MAX_RULES; s++)
			queue_item(make_rule(SLOT_W'(s)));
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					cnt = 7'd64;
					dacc = 1'b0;
				end
				1: begin
					cnt = 7'd127;
					dacc = 1'b1;
				end
				2: begin
					cnt = 7'd1;
					dacc = 1'b0;
				end
				3: begin
					cnt = 7'd65;
					dacc = 1'b1;
				end
				4: begin
					cnt = 7'd0;
					dacc = 1'b1;
				end
				7: begin
					cnt = 7'd64;
					dacc = 1'b1;
				end
				default: begin
					cnt = CFG_DAT_W'($urandom_range(0, 127));
					dacc = 1'($urandom_range(0, 1));
				end
			endcase
			wdat = CFG_DAT_W'($urandom);
			wdat[0] = dacc;
			write_reg(CFG_RULES_IN_USE, cnt);
			write_reg(CFG_DEFAULT_ACCEPT, wdat);
			idle_on = (p != 4 && p != RANDOM_PHASES - 1);
			if (p == 2)
				hold_requests++;
			eff = (scan_count == 0 || scan_count > MAX_RULES) ? MAX_RULES : scan_count;
			@(negedge clk);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 18) begin
					it = make_rule(SLOT_W'($urandom_range(0, MAX_RULES - 1)));
				end else begin
					it = packet_item(pick_proto(1'b1), pick_addr(), pick_addr(),
						pick_port(1'b1), pick_port(1'b1), $urandom_range(0, 9) == 0,
						$urandom_range(0, 9) != 0);
					// most packets aimed at one rule, sometimes with one field disturbed
					if ($urandom_range(0, 9) < 7) begin
						r = rule_shadow[SLOT_W'($urandom_range(0, eff - 1))];
						if (r.proto != PROTO_WILD)
							it.proto = r.proto;
						if (!r.wild[WILD_SRC])
							it.src = r.src;
						if (!r.wild[WILD_DST])
							it.dst = r.dst;
						if (r.sport != PORT_ANY)
							it.sport = r.sport;
						if (r.dport != PORT_ANY)
							it.dport = r.dport;
						case ($urandom_range(0, 9))
							0: it.proto = pick_proto(1'b1);
							1: it.src = pick_addr();
							2: it.dst = pick_addr();
							3: it.sport = pick_port(1'b1);
							4: it.dport = pick_port(1'b1);
							default: ;
						endcase
					end
				end
				queue_item(it);
			end
			settle();
		end

		if (errors == 0)
			$display("first_match_packet_rule_classifier test passed");
		else
			$display("first_match_packet_rule_classifier test failed");
		$finish;
	end

endmodule
